>>> design/wcct_pkg.sv
// ----------------------------------------------------------------------------
// wcct_pkg
// shared types and codes for the word class count table
// ----------------------------------------------------------------------------
package wcct_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int WORD_BYTES    = 32;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_EOM  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    localparam logic [7:0] NEWLINE = 8'd10;

    // one result transaction
    typedef struct packed {
        logic [7:0]  entry_index_out;
        logic        word_new;
        logic        table_full;
        logic [31:0] spam_hits;
        logic [31:0] ham_hits;
        logic [31:0] spam_emails;
        logic [31:0] ham_emails;
        logic        seen_mark;
        logic [5:0]  word_length;
        logic [7:0]  word_byte;
    } t_result;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'd65 && c <= 8'd90) r = c + 8'd32;
        return r;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        logic [31:0] r;
        r = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        return r;
    endfunction

endpackage

>>> design/wcct_out_reg.sv
// ----------------------------------------------------------------------------
// wcct_out_reg
// one-deep output register with valid/stall handshake
// ----------------------------------------------------------------------------
module wcct_out_reg
    import wcct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);
    logic r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_full  = r_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

>>> design/word_class_count_table.sv
// ----------------------------------------------------------------------------
// word_class_count_table
// word table with spam/ham occurrence and email counts
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid/o_stall) carries op, data byte, class bit, entry
//   index and byte position. op 0 bytes build a token; a newline looks it up
//   case-insensitively and bumps or appends the word (or flags table_full), giving one result.
//   op 1 ends an email and sweeps the table, no result. op 2 reads one entry.
//   output channel (o_valid/i_stall) holds one result in a register.
// sequencing:
//   token byte: taken in idle. read: S_RRD, S_RES, then S_PUT; a read at or
//   past the fill count goes straight to S_PUT. newline: a search reads one
//   entry at a time and compares one byte per cycle from the text memory,
//   then appends len bytes if the word is new.
//   end of email: each stored entry is read, then written back if marked.
//   the single-port state memories set this sequencing.
// reset:
//   the table and token are empty after reset; no clearing pass is needed
//   since only entries below the fill count are ever read.
// stall:
//   a finished result waits in the output register; the block works on the
//   next transaction and only waits when it has a new result to place.
// ----------------------------------------------------------------------------
module word_class_count_table
    import wcct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_spam,
    input  logic [7:0]  i_entry_index,
    input  logic [4:0]  i_byte_pos,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_entry_index_out,
    output logic        o_word_new,
    output logic        o_table_full,
    output logic [31:0] o_spam_hits,
    output logic [31:0] o_ham_hits,
    output logic [31:0] o_spam_emails,
    output logic [31:0] o_ham_emails,
    output logic        o_seen_mark,
    output logic [5:0]  o_word_length,
    output logic [7:0]  o_word_byte
);
    localparam int EW = $clog2(TABLE_ENTRIES);   // entry index bits
    localparam int BW = $clog2(WORD_BYTES);      // byte index bits
    localparam int CW = EW + 1;                  // fill count bits
    localparam int LW = $clog2(WORD_BYTES + 1);  // length bits

    // per-entry record: len, four counts, mark
    typedef struct packed {
        logic [LW-1:0] len;
        logic [31:0]   socc;
        logic [31:0]   hocc;
        logic [31:0]   smail;
        logic [31:0]   hmail;
        logic          mark;
    } t_rec;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SRD    = 11'b00000000010,  // read record of search entry
        S_SCMP   = 11'b00000000100,  // compare length, read text
        S_SBYTE  = 11'b00000001000,  // compare one byte per cycle
        S_APP    = 11'b00000010000,  // write token bytes to new entry
        S_UPD    = 11'b00000100000,  // write back record, fetch byte
        S_RES    = 11'b00001000000,  // form result
        S_ERD    = 11'b00010000000,  // sweep read
        S_EWR    = 11'b00100000000,  // sweep write
        S_RRD    = 11'b01000000000,  // read op record
        S_PUT    = 11'b10000000000   // wait for output register
    } t_state;

    t_state r_state, n_state;

    // memories
    t_rec      rec_mem [TABLE_ENTRIES];
    logic [7:0] text_mem [TABLE_ENTRIES*WORD_BYTES];
    logic [7:0] tok_mem [WORD_BYTES];

    logic          rec_we;
    logic [EW-1:0] rec_addr;
    t_rec          rec_wdata, r_rec_q;
    logic          txt_we;
    logic [EW+BW-1:0] txt_addr;
    logic [7:0]    txt_wdata, r_txt_q;
    logic          tok_we;
    logic [BW-1:0] tok_waddr, tok_raddr;
    logic [7:0]    r_tok_q;

    always_ff @(posedge i_clk) begin
        if (rec_we) rec_mem[rec_addr] <= rec_wdata;
        r_rec_q <= rec_mem[rec_addr];
    end
    always_ff @(posedge i_clk) begin
        if (txt_we) text_mem[txt_addr] <= txt_wdata;
        r_txt_q <= text_mem[txt_addr];
    end
    always_ff @(posedge i_clk) begin
        if (tok_we) tok_mem[tok_waddr] <= i_data_byte;
        r_tok_q <= tok_mem[tok_raddr];
    end

    // control registers
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_tlen, n_tlen;
    logic [CW-1:0] r_ent, n_ent;
    logic [LW-1:0] r_bi, n_bi;
    logic          r_spam, n_spam;
    logic [4:0]    r_pos, n_pos;
    logic          r_new, n_new;
    logic          r_read, n_read;
    t_rec          r_rec, n_rec;
    t_result       r_res, n_res;

    logic    out_load, out_full;
    t_result out_res;
    logic    in_acc;

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count; n_tlen = r_tlen; n_ent = r_ent; n_bi = r_bi;
        n_spam = r_spam; n_pos = r_pos; n_new = r_new;
        n_read = r_read; n_rec = r_rec; n_res = r_res;
        rec_we = 1'b0; rec_addr = r_ent[EW-1:0]; rec_wdata = r_rec;
        txt_we = 1'b0; txt_wdata = r_tok_q;
        txt_addr = {r_ent[EW-1:0], r_bi[BW-1:0]};
        tok_we = 1'b0; tok_waddr = r_tlen[BW-1:0]; tok_raddr = r_bi[BW-1:0];
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_spam = i_is_spam; n_pos = i_byte_pos;
                    case (t_op'(i_op))
                        OP_BYTE: begin
                            if (i_data_byte != NEWLINE) begin
                                if (32'(r_tlen) < 32'(WORD_BYTES)) begin
                                    tok_we = 1'b1;
                                    n_tlen = r_tlen + 1'b1;
                                end
                            end else begin
                                n_ent = '0; n_read = 1'b0;
                                n_state = S_SRD;
                            end
                        end
                        OP_EOM: begin
                            n_tlen = '0; n_ent = '0;
                            n_state = S_ERD;
                        end
                        OP_READ: begin
                            n_read = 1'b1;
                            n_res = '0;
                            n_res.entry_index_out = i_entry_index;
                            if (32'(i_entry_index) < 32'(r_count)) begin
                                n_ent = CW'(i_entry_index);
                                n_state = S_RRD;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SRD: begin
                // r_ent is entry under test; issue record read
                if (r_ent == r_count) begin
                    n_res = '0;
                    if (32'(r_count) < 32'(TABLE_ENTRIES)) begin
                        n_bi = '0; n_new = 1'b1;
                        n_state = S_APP;
                    end else begin
                        n_res.table_full = 1'b1;
                        n_tlen = '0;
                        n_state = S_PUT;
                    end
                end else begin
                    n_bi = '0;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                n_rec = r_rec_q;
                if (r_rec_q.len != r_tlen) begin
                    n_ent = r_ent + 1'b1;
                    n_state = S_SRD;
                end else if (r_tlen == '0) begin
                    n_new = 1'b0;
                    n_state = S_UPD;
                end else begin
                    n_state = S_SBYTE;   // addresses for byte 0 issued now
                end
            end
            S_SBYTE: begin
                if (fold(r_txt_q) != fold(r_tok_q)) begin
                    n_ent = r_ent + 1'b1;
                    n_state = S_SRD;
                end else if (r_bi + 1'b1 == r_tlen) begin
                    n_new = 1'b0;
                    n_state = S_UPD;
                end else begin
                    n_bi = r_bi + 1'b1;
                    tok_raddr = n_bi[BW-1:0];
                    txt_addr = {r_ent[EW-1:0], n_bi[BW-1:0]};
                end
            end
            S_APP: begin
                // token byte r_bi-1 is in r_tok_q; write it, fetch next
                if (r_bi != '0) begin
                    txt_we = 1'b1;
                    txt_addr = {r_ent[EW-1:0], BW'(r_bi - 1'b1)};
                end
                if (r_bi == r_tlen) begin
                    n_rec.len = r_tlen;
                    n_rec.socc = {31'd0, r_spam};
                    n_rec.hocc = {31'd0, !r_spam};
                    n_rec.smail = '0; n_rec.hmail = '0; n_rec.mark = 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_UPD;
                end else begin
                    n_bi = r_bi + 1'b1;
                end
            end
            S_UPD: begin
                if (!r_new) begin
                    if (r_spam) n_rec.socc = sat_inc(r_rec.socc);
                    else        n_rec.hocc = sat_inc(r_rec.hocc);
                    n_rec.mark = 1'b1;
                end
                rec_we = 1'b1; rec_wdata = n_rec;
                txt_addr = {r_ent[EW-1:0], r_pos[BW-1:0]};
                n_tlen = '0;
                n_state = S_RES;
            end
            S_RES: begin
                n_res.entry_index_out = r_ent[7:0];
                n_res.word_new   = r_new & !r_read;
                n_res.table_full = 1'b0;
                n_res.spam_hits  = r_rec.socc;
                n_res.ham_hits   = r_rec.hocc;
                n_res.spam_emails = r_rec.smail;
                n_res.ham_emails = r_rec.hmail;
                n_res.seen_mark  = r_rec.mark;
                n_res.word_length = 6'(r_rec.len);
                n_res.word_byte = ((LW+1)'(r_pos) < (LW+1)'(r_rec.len)
                                   && 32'(r_pos) < 32'(WORD_BYTES)) ? r_txt_q : 8'd0;
                n_state = S_PUT;
            end
            S_RRD: begin
                // record read issued in idle cycle via rec_addr
                n_rec = r_rec_q;
                txt_addr = {r_ent[EW-1:0], r_pos[BW-1:0]};
                n_state = S_RES;
            end
            S_ERD: begin
                if (r_ent == r_count) n_state = S_IDLE;
                else                  n_state = S_EWR;
            end
            S_EWR: begin
                n_rec = r_rec_q;
                if (r_rec_q.mark) begin
                    if (r_spam) n_rec.smail = sat_inc(r_rec_q.smail);
                    else        n_rec.hmail = sat_inc(r_rec_q.hmail);
                    n_rec.mark = 1'b0;
                    rec_we = 1'b1; rec_wdata = n_rec;
                end
                n_ent = r_ent + 1'b1;
                n_state = S_ERD;
            end
            S_PUT: begin
                if (!out_full || !i_stall) begin
                    out_load = 1'b1;
                    n_new = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE && in_acc && t_op'(i_op) == OP_READ)
            rec_addr = i_entry_index[EW-1:0];
    end

    // read case: word_new must be zero; S_RES uses r_new which idles at 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_tlen  <= '0;
            r_new   <= 1'b0;
            r_read  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_tlen  <= n_tlen;
            r_new   <= n_new;
            r_read  <= n_read;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent  <= n_ent;
        r_bi   <= n_bi;
        r_spam <= n_spam;
        r_pos  <= n_pos;
        r_rec  <= n_rec;
        r_res  <= n_res;
    end

    wcct_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (r_res),
        .o_full  (out_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_entry_index_out = out_res.entry_index_out;
    assign o_word_new        = out_res.word_new;
    assign o_table_full      = out_res.table_full;
    assign o_spam_hits       = out_res.spam_hits;
    assign o_ham_hits        = out_res.ham_hits;
    assign o_spam_emails     = out_res.spam_emails;
    assign o_ham_emails      = out_res.ham_emails;
    assign o_seen_mark       = out_res.seen_mark;
    assign o_word_length     = out_res.word_length;
    assign o_word_byte       = out_res.word_byte;

`ifndef SYNTH
    // fill count never passes the table size
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(TABLE_ENTRIES))
        else $error("fill count overflow");
    // token length never passes the word size
    a_tlen_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tlen) <= 32'(WORD_BYTES))
        else $error("token length overflow");
    // a result is loaded only from the put state
    a_load_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == S_PUT))
        else $error("result loaded outside put state");
`endif
endmodule
